// ----- hw/rtl/bmf_pkg.sv -----
package bmf_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int WINDOW     = 5;
  localparam int HALF       = (WINDOW - 1) / 2;
  localparam int SLOTS      = WINDOW + 1;
  localparam int TAPS       = WINDOW * WINDOW;

  // Channel layout of one pixel
  localparam int NUM_CH = 3;
  localparam int CH_W   = 8;
  localparam int PIX_W  = NUM_CH * CH_W;

  // Register and counter widths
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int OROW_W   = $clog2(MAX_HEIGHT);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int ADDR_W   = $clog2(SLOTS * MAX_WIDTH);
  localparam int RAM_DEPTH = SLOTS * MAX_WIDTH;
  localparam int OFF_W    = $clog2(WINDOW);
  localparam int LAG_W    = $clog2(HALF * MAX_WIDTH + HALF + 2);
  localparam int SUM_W    = $clog2(TAPS * ((1 << CH_W) - 1) + 1);
  localparam int CNT_W    = $clog2(TAPS + 1);
  localparam int DIV_W    = $clog2(SUM_W);

  // Register reset values
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY   = 2'd2;

  // Input request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic issue;
    logic div_step;
    logic load;
  } bmf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;
    logic last_tap;
    logic div_last;
    logic out_free;
  } bmf_stat_t;

endpackage

// ----- hw/rtl/bmf_in_if.sv -----
interface bmf_in_if;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [bmf_pkg::CH_W-1:0] in_red;
  logic [bmf_pkg::CH_W-1:0] in_green;
  logic [bmf_pkg::CH_W-1:0] in_blue;

  modport source (output valid, output req_type, output in_red, output in_green,
                  output in_blue, input ready);
  modport sink (input valid, input req_type, input in_red, input in_green,
                input in_blue, output ready);
endinterface

// ----- hw/rtl/bmf_out_if.sv -----
interface bmf_out_if;
  logic                    valid;
  logic                    ready;
  logic [bmf_pkg::CH_W-1:0] out_red;
  logic [bmf_pkg::CH_W-1:0] out_green;
  logic [bmf_pkg::CH_W-1:0] out_blue;
  logic                    frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input frame_end, output ready);
endinterface

// ----- hw/rtl/bmf_ram.sv -----
module bmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bmf_ctrl.sv -----
module bmf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmf_pkg::bmf_stat_t stat,
  output bmf_pkg::bmf_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ACCUM  = 5'b00010,
    ST_FLUSH  = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } bmf_state_t;

  bmf_state_t state;
  bmf_state_t state_next;

  // Next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && stat.emit) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.issue = 1'b1;
        if (stat.last_tap) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The window sweep only ends on the datapath's last tap.
  a_flush_after_last_tap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> $past(stat.last_tap))
    else $error("flush entered without the last window tap");

  // A loaded result always returns the controller to accepting items.
  a_load_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_IDLE))
    else $error("controller did not return to idle after a result");

endmodule

// ----- hw/rtl/bmf_datapath.sv -----
module bmf_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmf_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             req_type,
  input  logic [bmf_pkg::CH_W-1:0]         in_red,
  input  logic [bmf_pkg::CH_W-1:0]         in_green,
  input  logic [bmf_pkg::CH_W-1:0]         in_blue,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [bmf_pkg::CH_W-1:0]         out_red,
  output logic [bmf_pkg::CH_W-1:0]         out_green,
  output logic [bmf_pkg::CH_W-1:0]         out_blue,
  output logic                             frame_end,
  input  bmf_pkg::bmf_cmd_t                cmd,
  output bmf_pkg::bmf_stat_t               stat
);

  localparam int RRW = bmf_pkg::HEIGHT_W + 1;
  localparam int CCW = bmf_pkg::WIDTH_W + 1;
  localparam int SSW = bmf_pkg::SLOT_W + 2;

  // Configuration registers
  logic [bmf_pkg::WIDTH_W-1:0]  width_reg;
  logic [bmf_pkg::HEIGHT_W-1:0] height_reg;
  logic                         gray_reg;

  // Frame position counters
  logic [bmf_pkg::COL_W-1:0]    in_col;
  logic [bmf_pkg::HEIGHT_W-1:0] in_row;
  logic [bmf_pkg::SLOT_W-1:0]   in_slot;
  logic [bmf_pkg::COL_W-1:0]    out_col;
  logic [bmf_pkg::OROW_W-1:0]   out_row;
  logic [bmf_pkg::SLOT_W-1:0]   out_slot;
  logic [bmf_pkg::LAG_W-1:0]    step;

  // Window sweep and arithmetic
  logic [bmf_pkg::OFF_W-1:0]    tap_r;
  logic [bmf_pkg::OFF_W-1:0]    tap_c;
  logic                         rd_valid;
  logic [bmf_pkg::SUM_W-1:0]    acc [bmf_pkg::NUM_CH];
  logic [bmf_pkg::CNT_W-1:0]    rem [bmf_pkg::NUM_CH];
  logic [bmf_pkg::CNT_W-1:0]    count;
  logic [bmf_pkg::DIV_W-1:0]    div_cnt;

  // Combinational helpers
  logic [bmf_pkg::WIDTH_W-1:0]  w_eff;
  logic [bmf_pkg::HEIGHT_W-1:0] h_eff;
  logic [bmf_pkg::LAG_W-1:0]    tail;
  logic [bmf_pkg::LAG_W-1:0]    lag;
  logic                         taking;
  logic                         ignored;
  logic                         act;
  logic                         pix_write;
  logic                         cfg_hit;
  logic                         last;
  logic                         in_col_wrap;
  logic                         out_col_wrap;
  logic [RRW-1:0]               rr_u;
  logic [CCW-1:0]               cc_u;
  logic                         row_ok;
  logic                         col_ok;
  logic [SSW-1:0]               slot_sum;
  logic [bmf_pkg::SLOT_W-1:0]   rd_slot;
  logic [bmf_pkg::COL_W-1:0]    rd_col;
  logic [bmf_pkg::ADDR_W-1:0]   raddr;
  logic [bmf_pkg::ADDR_W-1:0]   waddr;
  logic [bmf_pkg::PIX_W-1:0]    rdata;
  logic [bmf_pkg::CNT_W-1:0]    divisor;
  logic [bmf_pkg::CNT_W:0]      trial [bmf_pkg::NUM_CH];
  logic                         ge [bmf_pkg::NUM_CH];
  logic [bmf_pkg::CNT_W-1:0]    rem_next [bmf_pkg::NUM_CH];
  logic [bmf_pkg::SUM_W-1:0]    acc_next [bmf_pkg::NUM_CH];

  // Effective frame size and output lag
  always_comb begin
    if (width_reg == '0) begin
      w_eff = bmf_pkg::WIDTH_W'(1);
    end else if (width_reg > bmf_pkg::WIDTH_W'(bmf_pkg::MAX_WIDTH)) begin
      w_eff = bmf_pkg::WIDTH_W'(bmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    if (height_reg == '0) begin
      h_eff = bmf_pkg::HEIGHT_W'(1);
    end else if (height_reg > bmf_pkg::HEIGHT_W'(bmf_pkg::MAX_HEIGHT)) begin
      h_eff = bmf_pkg::HEIGHT_W'(bmf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_reg;
    end
    if ((w_eff - bmf_pkg::WIDTH_W'(1)) < bmf_pkg::WIDTH_W'(bmf_pkg::HALF)) begin
      tail = bmf_pkg::LAG_W'(w_eff - bmf_pkg::WIDTH_W'(1));
    end else begin
      tail = bmf_pkg::LAG_W'(bmf_pkg::HALF);
    end
    lag = bmf_pkg::LAG_W'(bmf_pkg::HALF) * bmf_pkg::LAG_W'(w_eff) + tail;
  end

  // Item decode: a drain tick while pixels are still due is dropped.
  assign taking    = in_row < h_eff;
  assign ignored   = taking && (req_type == bmf_pkg::REQ_DRAIN);
  assign act       = cmd.take && !ignored;
  assign pix_write = act && taking;
  assign cfg_hit   = cfg_write && ((cfg_index == bmf_pkg::REG_WIDTH) ||
                     (cfg_index == bmf_pkg::REG_HEIGHT) || (cfg_index == bmf_pkg::REG_GRAY));

  assign in_col_wrap  = (bmf_pkg::WIDTH_W'(in_col) + bmf_pkg::WIDTH_W'(1)) >= w_eff;
  assign out_col_wrap = (bmf_pkg::WIDTH_W'(out_col) + bmf_pkg::WIDTH_W'(1)) >= w_eff;
  assign last = ((bmf_pkg::HEIGHT_W'(out_row) + bmf_pkg::HEIGHT_W'(1)) >= h_eff) &&
                out_col_wrap;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= bmf_pkg::WIDTH_W'(bmf_pkg::WIDTH_RESET);
      height_reg <= bmf_pkg::HEIGHT_W'(bmf_pkg::HEIGHT_RESET);
      gray_reg   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmf_pkg::REG_WIDTH:  width_reg  <= cfg_data[bmf_pkg::WIDTH_W-1:0];
        bmf_pkg::REG_HEIGHT: height_reg <= cfg_data[bmf_pkg::HEIGHT_W-1:0];
        bmf_pkg::REG_GRAY:   gray_reg   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Position counters; a register write or the frame's last result restarts them.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit || (cmd.load && last)) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      step     <= '0;
    end else begin
      if (pix_write) begin
        if (in_col_wrap) begin
          in_col  <= '0;
          in_row  <= in_row + bmf_pkg::HEIGHT_W'(1);
          in_slot <= (in_slot == bmf_pkg::SLOT_W'(bmf_pkg::SLOTS - 1)) ? '0 :
                     in_slot + bmf_pkg::SLOT_W'(1);
        end else begin
          in_col <= in_col + bmf_pkg::COL_W'(1);
        end
      end
      // The step count saturates just past the lag.
      if (act && (step <= lag)) begin
        step <= step + bmf_pkg::LAG_W'(1);
      end
      if (cmd.load) begin
        if (out_col_wrap) begin
          out_col  <= '0;
          out_row  <= out_row + bmf_pkg::OROW_W'(1);
          out_slot <= (out_slot == bmf_pkg::SLOT_W'(bmf_pkg::SLOTS - 1)) ? '0 :
                      out_slot + bmf_pkg::SLOT_W'(1);
        end else begin
          out_col <= out_col + bmf_pkg::COL_W'(1);
        end
      end
    end
  end

  // Window tap address: row and column checked against the frame edges.
  always_comb begin
    rr_u   = RRW'(out_row) + RRW'(tap_r);
    cc_u   = CCW'(out_col) + CCW'(tap_c);
    row_ok = (rr_u >= RRW'(bmf_pkg::HALF)) &&
             (rr_u < (RRW'(h_eff) + RRW'(bmf_pkg::HALF)));
    col_ok = (cc_u >= CCW'(bmf_pkg::HALF)) &&
             (cc_u < (CCW'(w_eff) + CCW'(bmf_pkg::HALF)));
    rd_col = bmf_pkg::COL_W'(cc_u - CCW'(bmf_pkg::HALF));
    slot_sum = SSW'(out_slot) + SSW'(tap_r) + SSW'(bmf_pkg::SLOTS - bmf_pkg::HALF);
    if (slot_sum >= SSW'(2 * bmf_pkg::SLOTS)) begin
      rd_slot = bmf_pkg::SLOT_W'(slot_sum - SSW'(2 * bmf_pkg::SLOTS));
    end else if (slot_sum >= SSW'(bmf_pkg::SLOTS)) begin
      rd_slot = bmf_pkg::SLOT_W'(slot_sum - SSW'(bmf_pkg::SLOTS));
    end else begin
      rd_slot = bmf_pkg::SLOT_W'(slot_sum);
    end
    raddr = bmf_pkg::ADDR_W'(rd_slot) * bmf_pkg::ADDR_W'(bmf_pkg::MAX_WIDTH) +
            bmf_pkg::ADDR_W'(rd_col);
    waddr = bmf_pkg::ADDR_W'(in_slot) * bmf_pkg::ADDR_W'(bmf_pkg::MAX_WIDTH) +
            bmf_pkg::ADDR_W'(in_col);
  end

  // Line store: the last SLOTS rows of the frame.
  bmf_ram #(
    .WIDTH (bmf_pkg::PIX_W),
    .DEPTH (bmf_pkg::RAM_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (pix_write),
    .waddr (waddr),
    .wdata ({in_blue, in_green, in_red}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Tap sweep over the window, one read per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_r    <= '0;
      tap_c    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue && row_ok && col_ok;
      if (cmd.take) begin
        tap_r <= '0;
        tap_c <= '0;
      end else if (cmd.issue) begin
        if (tap_c == bmf_pkg::OFF_W'(bmf_pkg::WINDOW - 1)) begin
          tap_c <= '0;
          tap_r <= tap_r + bmf_pkg::OFF_W'(1);
        end else begin
          tap_c <= tap_c + bmf_pkg::OFF_W'(1);
        end
      end
    end
  end

  // One restoring division step per cycle for all channels.
  assign divisor = (count == '0) ? bmf_pkg::CNT_W'(1) : count;

  always_comb begin
    for (int ch = 0; ch < bmf_pkg::NUM_CH; ch++) begin
      trial[ch]    = {rem[ch], acc[ch][bmf_pkg::SUM_W-1]};
      ge[ch]       = trial[ch] >= (bmf_pkg::CNT_W + 1)'(divisor);
      rem_next[ch] = ge[ch] ? bmf_pkg::CNT_W'(trial[ch] - (bmf_pkg::CNT_W + 1)'(divisor)) :
                              bmf_pkg::CNT_W'(trial[ch]);
      acc_next[ch] = {acc[ch][bmf_pkg::SUM_W-2:0], ge[ch]};
    end
  end

  // Sums accumulate as reads return; the same registers then shift out quotients.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      div_cnt <= '0;
    end else if (cmd.take) begin
      count   <= '0;
      div_cnt <= '0;
    end else if (rd_valid) begin
      count <= count + bmf_pkg::CNT_W'(1);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + bmf_pkg::DIV_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < bmf_pkg::NUM_CH; ch++) begin
      if (cmd.take) begin
        acc[ch] <= '0;
        rem[ch] <= '0;
      end else if (rd_valid) begin
        acc[ch] <= acc[ch] + bmf_pkg::SUM_W'(rdata[ch*bmf_pkg::CH_W +: bmf_pkg::CH_W]);
      end else if (cmd.div_step) begin
        acc[ch] <= acc_next[ch];
        rem[ch] <= rem_next[ch];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_red   <= acc[0][bmf_pkg::CH_W-1:0];
      out_green <= gray_reg ? '0 : acc[1][bmf_pkg::CH_W-1:0];
      out_blue  <= gray_reg ? '0 : acc[2][bmf_pkg::CH_W-1:0];
      frame_end <= last;
    end
  end

  // Status toward the controller
  always_comb begin
    stat.emit     = !ignored && (step >= lag);
    stat.last_tap = (tap_r == bmf_pkg::OFF_W'(bmf_pkg::WINDOW - 1)) &&
                    (tap_c == bmf_pkg::OFF_W'(bmf_pkg::WINDOW - 1));
    stat.div_last = div_cnt == bmf_pkg::DIV_W'(bmf_pkg::SUM_W - 1);
    stat.out_free = !out_valid || out_ready;
  end

  // The centre pixel is always inside the frame, so a result never divides by zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (count != '0))
    else $error("result loaded with an empty neighbour count");

  // Read data is only summed for a tap issued the cycle before.
  a_read_follows_issue: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(cmd.issue))
    else $error("read data counted without an issued tap");

  // Each sweep starts from cleared sums.
  a_sweep_starts_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && (tap_r == '0) && (tap_c == '0)) |-> ((count == '0) && !rd_valid))
    else $error("window sweep started with stale sums");

endmodule

// ----- hw/rtl/box_mean_filter_5x5.sv -----
// A pixel completing a window, once accepted, takes 25 line-store reads, one read
// flush, 13 divide steps and the output load, which waits until the output is free.
// No new item is taken before that load, so the single read port and the bit-serial
// divider bound the pace; items that give no result are taken each cycle while idle.
// Reset (rst, synchronous): registers return to 1024 x 1024 color, counters clear;
// the line store is not cleared, since only pixels of the current frame are read.
module box_mean_filter_5x5 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmf_pkg::CFG_W-1:0]     cfg_data,
  bmf_in_if.sink                        pix_in,
  bmf_out_if.source                     pix_out
);

  bmf_pkg::bmf_cmd_t  cmd;
  bmf_pkg::bmf_stat_t stat;

  // Sequencer
  bmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (pix_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Line store, window sums and divider
  bmf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_type  (pix_in.req_type),
    .in_red    (pix_in.in_red),
    .in_green  (pix_in.in_green),
    .in_blue   (pix_in.in_blue),
    .out_ready (pix_out.ready),
    .out_valid (pix_out.valid),
    .out_red   (pix_out.out_red),
    .out_green (pix_out.out_green),
    .out_blue  (pix_out.out_blue),
    .frame_end (pix_out.frame_end),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
